### rtl/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg: shared types and constants of the TFTP write receiver
// Holds the request, result and internal command item types, the opcode and
// error code values and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package twr_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BLOCK_SIZE = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] TIMEOUT_RST    = 16'd5000;
    localparam logic [10:0] BLOCK_SIZE_RST = 11'd512;

    // Packet framing.
    localparam logic [10:0] MAX_PACKET = 11'd516;
    localparam logic [10:0] MIN_LEN    = 11'd2;
    localparam logic [10:0] HDR_LEN    = 11'd4;

    // TFTP opcodes seen on the receive side.
    localparam logic [15:0] OP_RRQ  = 16'd1;
    localparam logic [15:0] OP_WRQ  = 16'd2;
    localparam logic [15:0] OP_DATA = 16'd3;

    // Reply kinds and TFTP error codes.
    localparam logic        KIND_ACK       = 1'b0;
    localparam logic        KIND_ERROR     = 1'b1;
    localparam logic [15:0] ERR_UNDEF      = 16'd0;
    localparam logic [15:0] ERR_NOT_FOUND  = 16'd1;
    localparam logic [15:0] ERR_ILLEGAL_OP = 16'd4;

    // Queue depths.
    localparam int CMD_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_TIMEOUT,
        MSG_BAD_NAME,
        MSG_BUSY,
        MSG_NO_XFER,
        MSG_SHORT_PKT,
        MSG_READ_UNSUP,
        MSG_UNSUP_OP
    } t_msg;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_WRQ,
        CMD_DATA,
        CMD_RRQ,
        CMD_OTHER
    } t_cmd_kind;

    typedef struct packed {
        logic        req_type;
        logic [15:0] opcode;
        logic [15:0] block_num;
        logic [10:0] pkt_len;
        logic        name_ok;
        logic [31:0] src_addr;
        logic [15:0] src_port;
    } t_req;

    typedef struct packed {
        logic        reply_kind;
        logic [15:0] reply_value;
        logic [2:0]  msg_id;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic        done_res;
        logic [31:0] total_bytes;
    } t_res;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_cmd_kind   kind;
        logic        name_ok;
        logic [15:0] block_num;
        logic [10:0] data_len;
        logic        short_pkt;
        logic [31:0] src_addr;
        logic [15:0] src_port;
    } t_cmd;

    // Configuration seen by the back.
    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [10:0] block_size;
        logic        session_clear;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/twr_fifo.sv
// ----------------------------------------------------------------------------
// twr_fifo: small synchronous queue
// Register-based first-in first-out queue with a count, used between the
// front and the back and again in front of the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire T     i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output T          o_data,
    output logic      o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    T                r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == CntW'($past(r_count) + 1'b1)))
        else $error("queue count did not grow on a lone push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == CntW'($past(r_count) - 1'b1)))
        else $error("queue count did not shrink on a lone pop");

endmodule

`default_nettype wire

### rtl/twr_front.sv
// ----------------------------------------------------------------------------
// twr_front: request classifier
// Accepts request items, drops those that can have no effect and turns the
// rest into commands with the packet length already clipped and decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_front (
    input  wire logic          i_enable,
    input  wire logic          i_push,
    input  wire twr_pkg::t_req i_item,
    input  wire logic          i_cmd_full,
    output logic               o_cmd_push,
    output twr_pkg::t_cmd      o_cmd
);
    import twr_pkg::*;

    logic [10:0] clip_len;
    logic        keep;

    always_comb begin
        clip_len = (i_item.pkt_len > MAX_PACKET) ? MAX_PACKET : i_item.pkt_len;

        // Ticks always go on; headers need at least the opcode bytes.
        keep = i_item.req_type || (i_item.pkt_len >= MIN_LEN);

        o_cmd.name_ok   = i_item.name_ok;
        o_cmd.block_num = i_item.block_num;
        o_cmd.short_pkt = (clip_len < HDR_LEN);
        o_cmd.data_len  = clip_len - HDR_LEN;
        o_cmd.src_addr  = i_item.src_addr;
        o_cmd.src_port  = i_item.src_port;

        if (i_item.req_type) begin
            o_cmd.kind = CMD_TICK;
        end else if (i_item.opcode == OP_WRQ) begin
            o_cmd.kind = CMD_WRQ;
        end else if (i_item.opcode == OP_DATA) begin
            o_cmd.kind = CMD_DATA;
        end else if (i_item.opcode == OP_RRQ) begin
            o_cmd.kind = CMD_RRQ;
        end else begin
            o_cmd.kind = CMD_OTHER;
        end

        // A disabled server swallows every item without a trace.
        o_cmd_push = i_push && !i_cmd_full && i_enable && keep;
    end

endmodule

`default_nettype wire

### rtl/twr_back.sv
// ----------------------------------------------------------------------------
// twr_back: session engine
// Owns the transfer session state, executes one command per cycle while the
// reply queue has room, and builds the reply item for it.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire twr_pkg::t_cfg i_cfg,
    input  wire twr_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output twr_pkg::t_res      o_res
);
    import twr_pkg::*;

    logic        r_active;
    logic [15:0] r_last_block;
    logic [31:0] r_byte_total;
    logic [15:0] r_idle;
    logic [31:0] r_client_addr;
    logic [15:0] r_client_port;

    logic        n_active;
    logic [15:0] n_last_block;
    logic [31:0] n_byte_total;
    logic [15:0] n_idle;
    logic [31:0] n_client_addr;
    logic [15:0] n_client_port;

    logic [16:0] idle_inc;
    logic [32:0] sum;
    logic [31:0] sat_total;
    logic        in_order;
    logic        emit;
    logic        end_sess;

    always_comb begin
        idle_inc  = {1'b0, r_idle} + 17'd1;
        sum       = {1'b0, r_byte_total} + 33'(i_cmd.data_len);
        sat_total = sum[32] ? '1 : sum[31:0];
        in_order  = ({1'b0, i_cmd.block_num} == ({1'b0, r_last_block} + 17'd1));

        o_cmd_pop = i_cmd_valid && !i_res_full;

        n_active      = r_active;
        n_last_block  = r_last_block;
        n_byte_total  = r_byte_total;
        n_idle        = r_idle;
        n_client_addr = r_client_addr;
        n_client_port = r_client_port;
        emit          = 1'b0;
        end_sess      = 1'b0;

        o_res.reply_kind  = KIND_ACK;
        o_res.reply_value = '0;
        o_res.msg_id      = MSG_NONE;
        o_res.done_res    = 1'b0;
        o_res.total_bytes = '0;

        if (o_cmd_pop) begin
            if (i_cmd.kind != CMD_TICK) begin
                // Every packet retargets the client, and its reply goes there.
                n_client_addr = i_cmd.src_addr;
                n_client_port = i_cmd.src_port;
            end
            case (i_cmd.kind)
                CMD_TICK: begin
                    if (r_active) begin
                        if (idle_inc > {1'b0, i_cfg.timeout_ticks}) begin
                            emit              = 1'b1;
                            end_sess          = 1'b1;
                            o_res.reply_kind  = KIND_ERROR;
                            o_res.reply_value = ERR_UNDEF;
                            o_res.msg_id      = MSG_TIMEOUT;
                        end else begin
                            n_idle = idle_inc[15:0];
                        end
                    end
                end
                CMD_WRQ: begin
                    emit = 1'b1;
                    if (!i_cmd.name_ok) begin
                        o_res.reply_kind  = KIND_ERROR;
                        o_res.reply_value = ERR_NOT_FOUND;
                        o_res.msg_id      = MSG_BAD_NAME;
                    end else if (r_active) begin
                        o_res.reply_kind  = KIND_ERROR;
                        o_res.reply_value = ERR_UNDEF;
                        o_res.msg_id      = MSG_BUSY;
                    end else begin
                        n_active     = 1'b1;
                        n_last_block = '0;
                        n_byte_total = '0;
                        n_idle       = '0;
                    end
                end
                CMD_DATA: begin
                    emit = 1'b1;
                    if (!r_active) begin
                        o_res.reply_kind  = KIND_ERROR;
                        o_res.reply_value = ERR_UNDEF;
                        o_res.msg_id      = MSG_NO_XFER;
                    end else if (i_cmd.short_pkt) begin
                        end_sess          = 1'b1;
                        o_res.reply_kind  = KIND_ERROR;
                        o_res.reply_value = ERR_UNDEF;
                        o_res.msg_id      = MSG_SHORT_PKT;
                    end else if (!in_order) begin
                        // Repeat the previous acknowledgment.
                        o_res.reply_value = r_last_block;
                    end else begin
                        o_res.reply_value = i_cmd.block_num;
                        n_last_block      = i_cmd.block_num;
                        n_byte_total      = sat_total;
                        n_idle            = '0;
                        if (i_cmd.data_len < i_cfg.block_size) begin
                            end_sess          = 1'b1;
                            o_res.done_res    = 1'b1;
                            o_res.total_bytes = sat_total;
                        end
                    end
                end
                CMD_RRQ: begin
                    emit              = 1'b1;
                    o_res.reply_kind  = KIND_ERROR;
                    o_res.reply_value = ERR_ILLEGAL_OP;
                    o_res.msg_id      = MSG_READ_UNSUP;
                end
                default: begin
                    emit              = 1'b1;
                    o_res.reply_kind  = KIND_ERROR;
                    o_res.reply_value = ERR_ILLEGAL_OP;
                    o_res.msg_id      = MSG_UNSUP_OP;
                end
            endcase
        end

        // The reply carries the client as it stands before the session ends.
        o_res.dest_addr = n_client_addr;
        o_res.dest_port = n_client_port;
        o_res_push      = emit;

        if (end_sess || i_cfg.session_clear) begin
            n_active      = 1'b0;
            n_last_block  = '0;
            n_byte_total  = '0;
            n_idle        = '0;
            n_client_port = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_last_block  <= '0;
            r_byte_total  <= '0;
            r_idle        <= '0;
            r_client_addr <= '0;
            r_client_port <= '0;
        end else begin
            r_active      <= n_active;
            r_last_block  <= n_last_block;
            r_byte_total  <= n_byte_total;
            r_idle        <= n_idle;
            r_client_addr <= n_client_addr;
            r_client_port <= n_client_port;
        end
    end

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.done_res) |=> (!r_active && r_byte_total == '0))
        else $error("completed transfer left the session open");

    a_timeout_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.msg_id == MSG_TIMEOUT) |=> (!r_active && r_idle == '0))
        else $error("timeout left the session open");

    a_push_needs_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (o_cmd_pop && !i_res_full))
        else $error("reply pushed without a command taken");

    a_open_on_wrq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.kind == CMD_WRQ && i_cmd.name_ok && !r_active
         && !i_cfg.session_clear) |=> r_active)
        else $error("accepted write request did not open a session");

endmodule

`default_nettype wire

### rtl/tftp_write_receiver_unit.sv
// ----------------------------------------------------------------------------
// tftp_write_receiver_unit: receive side of a TFTP write session
// Takes parsed packet headers and millisecond ticks and answers each with at
// most one ACK or ERROR reply item addressed to the current client.
//
// Usage:
//   Request items enter through push/full; one is taken at every edge where
//   push is high and full is low. Reply items leave through empty/pop; the
//   oldest reply sits on o_result while empty is low and is taken at an edge
//   where pop is high. Configuration registers (enable, timeout_ticks,
//   block_size at indexes 0, 1, 2) are written through i_cfg_we/i_cfg_idx/
//   i_cfg_wdata while no item is in flight; a change of enable ends the session.
//   Throughput is one item per cycle while full is low. A reply reaches o_result
//   through two registered queues: the request is stored in the command queue,
//   and the session engine handles it from the head of that queue and writes the
//   reply straight into the reply queue, from which it is popped.
//   When the consumer stops popping, the reply queue fills, the session engine
//   stops taking commands, and after the command queue fills, full rises.
//   Nothing is lost. Synchronous reset empties both queues, clears the session
//   and loads the configuration reset values (server disabled).
// ----------------------------------------------------------------------------
`default_nettype none

module tftp_write_receiver_unit #(
    parameter int CMD_DEPTH = twr_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = twr_pkg::RES_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire twr_pkg::t_req              i_item,
    output logic                            empty,
    input  wire logic                       pop,
    output twr_pkg::t_res                   o_result,
    input  wire logic                       i_cfg_we,
    input  wire logic [twr_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [twr_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import twr_pkg::*;

    // Configuration registers.
    logic        r_enable;
    logic [15:0] r_timeout;
    logic [10:0] r_block_size;
    logic        n_enable;
    logic [15:0] n_timeout;
    logic [10:0] n_block_size;
    logic        session_clear;

    // Front to command queue.
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;

    // Command queue to back.
    t_cmd cmd_head;
    logic cmd_empty;
    logic cmd_pop;

    // Back to reply queue.
    t_cfg back_cfg;
    logic res_push;
    t_res res_in;
    logic res_full;

    // Register writes; a write to an index beyond the list does nothing.
    always_comb begin
        n_enable      = r_enable;
        n_timeout     = r_timeout;
        n_block_size  = r_block_size;
        session_clear = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: begin
                    n_enable      = i_cfg_wdata[0];
                    session_clear = (i_cfg_wdata[0] != r_enable);
                end
                CFG_TIMEOUT: begin
                    n_timeout = i_cfg_wdata;
                end
                CFG_BLOCK_SIZE: begin
                    n_block_size = i_cfg_wdata[10:0];
                end
                default: begin
                    n_enable = r_enable;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_timeout    <= TIMEOUT_RST;
            r_block_size <= BLOCK_SIZE_RST;
        end else begin
            r_enable     <= n_enable;
            r_timeout    <= n_timeout;
            r_block_size <= n_block_size;
        end
    end

    assign back_cfg.timeout_ticks = r_timeout;
    assign back_cfg.block_size    = r_block_size;
    assign back_cfg.session_clear = session_clear;

    // The input queue's full flag is the block's full flag.
    assign full = cmd_full;

    twr_front u_front (
        .i_enable   (r_enable),
        .i_push     (push),
        .i_item     (i_item),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    twr_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    twr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_cmd       (cmd_head),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    twr_fifo #(
        .T     (t_res),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire
